// File: sv/fdw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdw_pkg: shared types and constants of the delayed-window FIR filter
// Operation codes, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package fdw_pkg;

    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_COEFF  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [6:0] TAP_COUNT_RESET = 7'd64;

    localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] OUT_MIN = 16'sh8000;

    typedef struct packed {
        logic init_wr;
        logic start;
        logic issue;
        logic commit;
        logic coef_wr;
        logic clr_hist;
    } cmd_t;

    typedef struct packed {
        logic issue_last;
        logic len_zero;
        logic pipe_busy;
        logic out_free;
        logic init_last;
    } status_t;

endpackage : fdw_pkg
`default_nettype wire

// File: sv/fdw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdw_ctrl: sequencing state machine
// Coefficient clear sweep, item decode, tap issue and result commit.
// ----------------------------------------------------------------------------
module fdw_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       operation,
    output logic                  in_ready,
    input  wire fdw_pkg::status_t status,
    output fdw_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (operation)
                        fdw_pkg::OP_FILTER:
                        begin
                            cmd.start  = 1'b1;
                            state_next = status.len_zero ? ST_DRAIN : ST_RUN;
                        end
                        fdw_pkg::OP_COEFF:
                        begin
                            cmd.coef_wr = 1'b1;
                        end
                        fdw_pkg::OP_CLEAR:
                        begin
                            cmd.clr_hist = 1'b1;
                        end
                        default:
                        begin
                            cmd.clr_hist = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule : fdw_ctrl
`default_nettype wire

// File: sv/fdw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdw_datapath: history ring, coefficient memory and shared MAC
// Read stage, multiply stage, accumulate stage, round/saturate, output word.
// ----------------------------------------------------------------------------
module fdw_datapath
#(
    parameter int MAX_TAPS  = 64,
    parameter int ACC_WIDTH = 40
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fdw_pkg::cmd_t      cmd,
    output fdw_pkg::status_t        status,
    input  wire logic signed [15:0] sample,
    input  wire logic [5:0]         tap_index,
    input  wire logic signed [15:0] coeff_value,
    input  wire logic               cfg_valid,
    input  wire logic [6:0]         cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      filtered
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LW = $clog2(MAX_TAPS + 1);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam int IW = (LW > 6) ? LW : 6;
    localparam int SW = LW + 1;
    localparam int QW = ACC_WIDTH + 1 - 15;

    logic signed [15:0] hist_mem [MAX_TAPS];
    logic signed [15:0] coef_mem [MAX_TAPS];

    logic [6:0]                  tap_count_reg;
    logic [AW-1:0]               wp_reg;
    logic [LW-1:0]               fill_reg;
    logic [AW-1:0]               init_cnt_reg;
    logic [AW-1:0]               pos_reg;
    logic [AW-1:0]               k_reg;
    logic [LW-1:0]               remain_reg;
    logic signed [15:0]          sample_reg;
    logic                        s1_valid_reg;
    logic                        s2_valid_reg;
    logic                        hv_reg;
    logic signed [15:0]          hist_rd_reg;
    logic signed [15:0]          coef_rd_reg;
    logic signed [31:0]          prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic                        out_valid_reg;
    logic signed [15:0]          out_data_reg;

    logic [LW-1:0]               len;
    logic [SW-1:0]               start_sum;
    logic [AW-1:0]               start_pos;
    logic [IW-1:0]               idx_ext;
    logic                        idx_ok;
    logic signed [ACC_WIDTH:0]   round_sum;
    logic signed [QW-1:0]        round_q;
    logic signed [15:0]          sat_value;

    always_comb
    begin
        if (CW'(tap_count_reg) > CW'(MAX_TAPS))
        begin
            len = LW'(MAX_TAPS);
        end
        else
        begin
            len = LW'(tap_count_reg);
        end
        start_sum = SW'(wp_reg) + SW'(MAX_TAPS) - SW'(len);
        if (start_sum >= SW'(MAX_TAPS))
        begin
            start_pos = AW'(start_sum - SW'(MAX_TAPS));
        end
        else
        begin
            start_pos = AW'(start_sum);
        end
        idx_ext   = IW'(tap_index);
        idx_ok    = idx_ext < IW'(MAX_TAPS);
        round_sum = (ACC_WIDTH + 1)'(acc_reg) + (ACC_WIDTH + 1)'(16384);
        round_q   = QW'(round_sum >>> 15);
        if (round_q > QW'(fdw_pkg::OUT_MAX))
        begin
            sat_value = fdw_pkg::OUT_MAX;
        end
        else if (round_q < QW'(fdw_pkg::OUT_MIN))
        begin
            sat_value = fdw_pkg::OUT_MIN;
        end
        else
        begin
            sat_value = round_q[15:0];
        end
    end

    assign status.issue_last = remain_reg == LW'(1);
    assign status.len_zero   = len == '0;
    assign status.pipe_busy  = s1_valid_reg || s2_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.init_last  = init_cnt_reg == AW'(MAX_TAPS - 1);

    assign out_valid = out_valid_reg;
    assign filtered  = out_data_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fdw_pkg::TAP_COUNT_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            init_cnt_reg  <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            remain_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tap_count_reg <= cfg_data;
            end
            if (cmd.init_wr)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (cmd.start)
            begin
                pos_reg    <= start_pos;
                k_reg      <= '0;
                remain_reg <= len;
            end
            else if (cmd.issue)
            begin
                pos_reg    <= (pos_reg == AW'(MAX_TAPS - 1)) ? '0 : pos_reg + AW'(1);
                k_reg      <= k_reg + AW'(1);
                remain_reg <= remain_reg - LW'(1);
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.clr_hist)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
            end
            else if (cmd.commit)
            begin
                wp_reg <= (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + AW'(1);
                if (fill_reg != LW'(MAX_TAPS))
                begin
                    fill_reg <= fill_reg + LW'(1);
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hist_mem[wp_reg] <= sample_reg;
        end
        if (cmd.init_wr)
        begin
            coef_mem[init_cnt_reg] <= '0;
        end
        else if (cmd.coef_wr && idx_ok)
        begin
            coef_mem[idx_ext[AW-1:0]] <= coeff_value;
        end
        if (cmd.issue)
        begin
            hist_rd_reg <= hist_mem[pos_reg];
            coef_rd_reg <= coef_mem[k_reg];
            hv_reg      <= LW'(pos_reg) < fill_reg;
        end
    end

    // MAC pipeline and output word
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sample_reg <= sample;
        end
        if (s1_valid_reg)
        begin
            prod_reg <= (hv_reg ? hist_rd_reg : 16'sd0) * coef_rd_reg;
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_WIDTH'(prod_reg);
        end
        if (cmd.commit)
        begin
            out_data_reg <= sat_value;
        end
    end

endmodule : fdw_datapath
`default_nettype wire

// File: sv/fir_filter_delayed_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_delayed_window: streaming FIR over Q1.15 samples
// A filter word issues its L = min(tap_count, MAX_TAPS) taps to the MAC; the
// result is committed once the pipeline is empty and the output is free, and
// the next word is taken after that. Coefficient/clear words stay in idle.
// Rate is set by the single shared multiply-accumulate unit, one tap a cycle.
// Reset: coefficient clearing sweep over all MAX_TAPS entries, s_axis_tready low.
// ----------------------------------------------------------------------------
module fir_filter_delayed_window
#(
    parameter int MAX_TAPS  = 64,
    parameter int ACC_WIDTH = 40
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // sample[15:0], tap_index[21:16],
                                             // coeff_value[37:22], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // filtered[15:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data        // tap_count[6:0]
);

    fdw_pkg::cmd_t    cmd;
    fdw_pkg::status_t status;
    logic signed [15:0] filtered;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = filtered;

    fdw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .operation (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    fdw_datapath
    #(
        .MAX_TAPS  (MAX_TAPS),
        .ACC_WIDTH (ACC_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (s_axis_tdata[15:0]),
        .tap_index   (s_axis_tdata[21:16]),
        .coeff_value (s_axis_tdata[37:22]),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .filtered    (filtered)
    );

endmodule : fir_filter_delayed_window
`default_nettype wire

// File: sim/fir_output_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_output_checker: filtered-output checker for the delayed-window FIR
// Watches the sample, result and tap-count channels, keeps its own copy of
// the history ring, write pointer, coefficients and tap count, computes the
// expected filtered word for every accepted filter word and compares each
// accepted result against the oldest expected value.
// ----------------------------------------------------------------------------
module fir_output_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // sample[15:0], tap_index[21:16],
                                        // coeff_value[37:22], zero pad
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // filtered[15:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,       // tap_count[6:0]
    output int          fail_count,
    output int          pending,
    output int          checked
);

    logic signed [15:0] hist [64];
    logic signed [15:0] coef [64];
    logic [5:0]         wpos;
    logic [6:0]         tap_len;
    logic [15:0]        expected_filtered [$];
    int                 mismatches;
    int                 seen;

    assign fail_count = mismatches;
    assign checked    = seen;

    // Sum over the window of the min(tap_len, 64) samples before the current one,
    // coefficient 0 on the oldest; round half up, saturate to 16 bits.
    function automatic logic [15:0] window_output();
        logic [39:0]        acc;
        logic signed [31:0] prod;
        logic signed [40:0] rounded;
        logic [6:0]         len;
        logic [5:0]         pos;
        acc = '0;
        len = (tap_len > 7'd64) ? 7'd64 : tap_len;
        pos = wpos - len[5:0];
        for (int k = 0; k < len; k++) begin
            prod = hist[pos] * coef[k];
            acc  = acc + {{8{prod[31]}}, prod};
            pos  = pos + 6'd1;
        end
        rounded = $signed({acc[39], acc}) + 41'sd16384;
        rounded = rounded >>> 15;
        if (rounded > 41'sd32767)
            return fdw_pkg::OUT_MAX;
        if (rounded < -41'sd32768)
            return fdw_pkg::OUT_MIN;
        return rounded[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < 64; i++)
            begin
                hist[i] = '0;
                coef[i] = '0;
            end
            wpos    = '0;
            tap_len = fdw_pkg::TAP_COUNT_RESET;
            expected_filtered.delete();
            mismatches = 0;
            seen       = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tap_len = cfg_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                seen++;
                if (expected_filtered.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected filtered word, expected none, got %0d",
                             $time, $signed(m_axis_tdata));
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        mismatches++;
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, $signed(want), $signed(m_axis_tdata));
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    fdw_pkg::OP_FILTER:
                    begin
                        expected_filtered.push_back(window_output());
                        hist[wpos] = s_axis_tdata[15:0];
                        wpos       = wpos + 6'd1;
                    end
                    fdw_pkg::OP_COEFF:
                        coef[s_axis_tdata[21:16]] = s_axis_tdata[37:22];
                    fdw_pkg::OP_CLEAR:
                    begin
                        for (int i = 0; i < 64; i++)
                            hist[i] = '0;
                        wpos = '0;
                    end
                    default: ;
                endcase
            end
            pending = expected_filtered.size();
        end
    end

endmodule : fir_output_checker

// File: sim/tb_fir_filter_delayed_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_filter_delayed_window: stimulus and verdict for the FIR filter
// Directed words for extremes, rounding, saturation and zero length, then
// random sample/coefficient/clear traffic over several tap counts under three
// handshake pressure modes; results are judged by fir_output_checker.
// ----------------------------------------------------------------------------
module tb_fir_filter_delayed_window;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_500_000;
    localparam int         SEG_WORDS   = 125;
    localparam int         SETTLE      = 80;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // sample[15:0], tap_index[21:16],
                                       // coeff_value[37:22], zero pad
    logic [1:0]  s_axis_tuser  = '0;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // filtered[15:0]
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data      = '0;   // tap_count[6:0]

    int fail_count;
    int pending;
    int checked;
    int src_idle   = 15;
    int sink_idle  = 53;
    int cycle_count = 0;
    int n_filter = 0;
    int n_coeff  = 0;
    int n_clear  = 0;
    int n_cfg    = 0;

    logic [6:0] tap_choices [12] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2,
                                     7'd64, 7'd3, 7'd0, 7'd1, 7'd127, 7'd33};

    fir_filter_delayed_window dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    fir_output_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [15:0] smp,
                             input logic [5:0] idx, input logic [15:0] cv);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cv, idx, smp};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (op)
            fdw_pkg::OP_FILTER: n_filter++;
            fdw_pkg::OP_COEFF:  n_coeff++;
            fdw_pkg::OP_CLEAR:  n_clear++;
            default: ;
        endcase
    endtask

    // Hold the source until every filtered word is back, then let any
    // trailing coefficient/clear word finish.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_tap_count(input logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic [15:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0, 1, 2: pick_value = r[15:0];
            3, 4:    pick_value = {{6{r[9]}}, r[9:0]};
            default:
                case (r[1:0])
                    2'd0:    pick_value = 16'h8000;
                    2'd1:    pick_value = 16'h7FFF;
                    2'd2:    pick_value = 16'h0000;
                    default: pick_value = 16'hFFFF;
                endcase
        endcase
    endfunction

    initial
    begin
        int counted;
        int r;
        int seg;
        logic [6:0] tc;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full length after reset: extremes at both ends of the window
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd0, 16'h8000);
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd63, 16'h7FFF);
        send_word(fdw_pkg::OP_COEFF, 16'hFFFF, 6'd1, 16'h0001);
        send_word(fdw_pkg::OP_FILTER, 16'h7FFF, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'h8000, 6'd63, 16'hFFFF);
        send_word(fdw_pkg::OP_FILTER, 16'h0000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'hFFFF, 6'd0, 16'h0000);
        send_word(OP_UNUSED, 16'h1234, 6'd5, 16'h7FFF);
        send_word(fdw_pkg::OP_CLEAR, 16'h7FFF, 6'd63, 16'h8000);
        send_word(fdw_pkg::OP_FILTER, 16'h4D2, 6'd0, 16'h0000);
        drain();

        // two taps: round half up both signs, then saturation both ways
        write_tap_count(7'd2);
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'h4000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'hC000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd0, 16'h8000);
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd1, 16'h8000);
        send_word(fdw_pkg::OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd0, 16'h7FFF);
        send_word(fdw_pkg::OP_COEFF, 16'h0000, 6'd1, 16'h7FFF);
        send_word(fdw_pkg::OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        drain();

        // zero length: empty sum
        write_tap_count(7'd0);
        send_word(fdw_pkg::OP_FILTER, 16'h7FFF, 6'd0, 16'h0000);
        send_word(fdw_pkg::OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       begin src_idle = 15; sink_idle = 53; end
                1:       begin src_idle = 53; sink_idle = 15; end
                default: begin src_idle = 0;  sink_idle = 0;  end
            endcase
            for (int s = 0; s < 4; s++)
            begin
                seg = mode * 4 + s;
                tc  = (s == 3) ? 7'($urandom_range(127)) : tap_choices[seg];
                drain();
                write_tap_count(tc);
                counted = 0;
                while (counted < SEG_WORDS)
                begin
                    r = $urandom_range(99);
                    if (r < 74)
                    begin
                        send_word(fdw_pkg::OP_FILTER, pick_value(), 6'($urandom),
                                  16'($urandom));
                        counted++;
                    end
                    else if (r < 95)
                    begin
                        send_word(fdw_pkg::OP_COEFF, 16'($urandom), 6'($urandom),
                                  pick_value());
                        counted++;
                    end
                    else if (r < 97)
                    begin
                        send_word(fdw_pkg::OP_CLEAR, 16'($urandom), 6'($urandom),
                                  16'($urandom));
                        counted++;
                    end
                    else
                        send_word(OP_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
                end
            end
        end

        drain();
        if (pending != 0)
            $display("%0d filtered words never arrived", pending);
        $display("covered %0d filter, %0d coefficient and %0d clear words, %0d results checked",
                 n_filter, n_coeff, n_clear, checked);
        $display("across %0d tap-count writes (0 to 127) and three handshake pressure modes",
                 n_cfg);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_fir_filter_delayed_window

// File: fir_filter_delayed_window.f
sv/fdw_pkg.sv
sv/fdw_ctrl.sv
sv/fdw_datapath.sv
sv/fir_filter_delayed_window.sv
sim/fir_output_checker.sv
sim/tb_fir_filter_delayed_window.sv
